// File: rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the byte ring FIFO with peek.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned MAX_RESULTS   = 16;
  localparam int unsigned CAP_W         = 5;
  localparam int unsigned LOOK_W        = 5;
  localparam int unsigned OCC_W         = 5;
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [2:0] {
    CMD_PUT     = 3'd0,
    CMD_TRY_PUT = 3'd1,
    CMD_GET     = 3'd2,
    CMD_PEEK    = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [7:0]        data_in;
    logic [LOOK_W-1:0] look_ahead;
  } in_t;

  typedef struct packed {
    logic             status;
    logic             data_valid;
    logic [7:0]       data_out;
    logic             last;
    logic [OCC_W-1:0] occupancy;
    logic             is_full;
    logic             is_empty;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic do_put;
    logic do_get;
    logic do_clear;
    logic rd_head;
    logic rd_next;
    logic out_load;
    logic out_ram;
    logic out_status;
    logic out_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic peek_bad;
  } dp_sts_t;

endpackage

// File: rtl/byte_ring_fifo_with_peek.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek
// Byte ring FIFO with overwrite put, try put, get, peek and clear; the
// capacity in use comes from a configuration register, clamped to 1..DEPTH.
// ----------------------------------------------------------------------------
//  channel | ports                           | moves
//  --------+---------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data     | one command transaction
//  out     | out_valid, out_ready, out_data  | one result transaction
//  cfg     | cfg_we, cfg_wdata               | capacity write, no wait
//
//  Put, try put, clear, unknown and rejected commands: loaded on acceptance.
//  Get: one registered store read, loaded in S_GET once the output is free.
//  Peek of N bytes: one store read per byte, loaded when the output is free.
//  A new command is taken when idle and the output is free or being taken.
//  Reset is synchronous; the byte store needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_peek #(
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [brf_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  brf_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output brf_pkg::out_t             out_data
);

  brf_pkg::dp_cmd_t dp_cmd;
  brf_pkg::dp_sts_t dp_sts;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .in_look   (in_data.look_ahead),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  brf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_din    (in_data.data_in),
    .in_look   (in_data.look_ahead),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts),
    .out_data  (out_data)
  );

endmodule

// File: rtl/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl
// Command sequencer: decodes transactions, steps gets and peeks, owns
// the output valid.
// ----------------------------------------------------------------------------
module brf_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_cmd,
  input  logic [brf_pkg::LOOK_W-1:0]   in_look,
  output logic                         out_valid,
  input  logic                         out_ready,
  output brf_pkg::dp_cmd_t             dp_cmd,
  input  brf_pkg::dp_sts_t             dp_sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET,
    S_PEEK
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [brf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       out_free;
  logic                       accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dp_cmd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          dp_cmd.out_last = 1'b1;
          unique case (in_cmd)
            brf_pkg::CMD_PUT: begin
              dp_cmd.do_put   = 1'b1;
              dp_cmd.out_load = 1'b1;
            end
            brf_pkg::CMD_TRY_PUT: begin
              dp_cmd.do_put     = !dp_sts.full;
              dp_cmd.out_status = dp_sts.full;
              dp_cmd.out_load   = 1'b1;
            end
            brf_pkg::CMD_GET: begin
              if (dp_sts.empty) begin
                dp_cmd.out_status = 1'b1;
                dp_cmd.out_load   = 1'b1;
              end else begin
                dp_cmd.do_get  = 1'b1;
                dp_cmd.rd_head = 1'b1;
                state_nxt      = S_GET;
              end
            end
            brf_pkg::CMD_PEEK: begin
              if (dp_sts.peek_bad) begin
                dp_cmd.out_status = 1'b1;
                dp_cmd.out_load   = 1'b1;
              end else if (in_look == '0) begin
                dp_cmd.out_load = 1'b1;
              end else begin
                dp_cmd.rd_head = 1'b1;
                cnt_nxt        = brf_pkg::CNT_W'(in_look);
                state_nxt      = S_PEEK;
              end
            end
            brf_pkg::CMD_CLEAR: begin
              dp_cmd.do_clear = 1'b1;
              dp_cmd.out_load = 1'b1;
            end
            default: begin
              dp_cmd.out_status = 1'b1;
              dp_cmd.out_load   = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        if (out_free) begin
          dp_cmd.out_load = 1'b1;
          dp_cmd.out_ram  = 1'b1;
          dp_cmd.out_last = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_PEEK: begin
        if (out_free) begin
          dp_cmd.out_load = 1'b1;
          dp_cmd.out_ram  = 1'b1;
          if (cnt_r == brf_pkg::CNT_W'(1)) begin
            dp_cmd.out_last = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            dp_cmd.rd_next = 1'b1;
            cnt_nxt        = cnt_r - brf_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r <= cnt_nxt;
  end

endmodule

// File: rtl/brf_dp.sv
// ----------------------------------------------------------------------------
// brf_dp
// Datapath: byte store, ring positions, full flag, capacity register and
// the output register.
// ----------------------------------------------------------------------------
module brf_dp #(
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [brf_pkg::CAP_W-1:0]   cfg_wdata,
  input  logic [7:0]                  in_din,
  input  logic [brf_pkg::LOOK_W-1:0]  in_look,
  input  brf_pkg::dp_cmd_t            dp_cmd,
  output brf_pkg::dp_sts_t            dp_sts,
  output brf_pkg::out_t               out_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned SZ_W  = PTR_W + 1;
  localparam int unsigned CMP_W = (SZ_W > brf_pkg::CAP_W) ? SZ_W : brf_pkg::CAP_W;

  logic [brf_pkg::CAP_W-1:0] cap_r;
  logic [PTR_W-1:0]          wr_r, wr_nxt;
  logic [PTR_W-1:0]          rd_r, rd_nxt;
  logic                      full_r, full_nxt;
  logic [PTR_W-1:0]          pk_r;
  brf_pkg::out_t             out_r;

  logic [SZ_W-1:0]  cap_use;
  logic [CMP_W-1:0] cap_ext;
  logic [PTR_W-1:0] wr_wrap, rd_wrap, pk_wrap;
  logic [SZ_W-1:0]  held_cur, held_nxt;
  logic             empty_cur;
  logic [CMP_W-1:0] look_ext;
  logic [CMP_W-1:0] held_ext;
  logic [7:0]       ram_rdata;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] pos,
                                                 input logic [SZ_W-1:0]  cap);
    logic [SZ_W-1:0] n;
    n = SZ_W'(pos) + SZ_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic logic [SZ_W-1:0] held_of(input logic [PTR_W-1:0] wr,
                                              input logic [PTR_W-1:0] rd,
                                              input logic             full,
                                              input logic [SZ_W-1:0]  cap);
    logic [SZ_W-1:0] d;
    d = SZ_W'(wr) - SZ_W'(rd);
    if (full) begin
      return cap;
    end else if (wr >= rd) begin
      return d;
    end else begin
      return cap + d;
    end
  endfunction

  assign cap_ext = CMP_W'(cap_r);

  always_comb begin
    if (cap_ext == '0) begin
      cap_use = SZ_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      cap_use = SZ_W'(DEPTH);
    end else begin
      cap_use = SZ_W'(cap_r);
    end
  end

  assign wr_wrap = wrap_next(wr_r, cap_use);
  assign rd_wrap = wrap_next(rd_r, cap_use);
  assign pk_wrap = wrap_next(pk_r, cap_use);

  assign held_cur  = held_of(wr_r, rd_r, full_r, cap_use);
  assign empty_cur = !full_r && (wr_r == rd_r);
  assign look_ext  = CMP_W'(in_look);
  assign held_ext  = CMP_W'(held_cur);

  assign dp_sts.empty    = empty_cur;
  assign dp_sts.full     = full_r;
  assign dp_sts.peek_bad = empty_cur || (look_ext > held_ext)
                           || (in_look > brf_pkg::LOOK_W'(brf_pkg::MAX_RESULTS));

  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    full_nxt = full_r;
    if (dp_cmd.do_clear) begin
      wr_nxt   = '0;
      rd_nxt   = '0;
      full_nxt = 1'b0;
    end else if (dp_cmd.do_put) begin
      if (full_r) begin
        rd_nxt = rd_wrap;
      end
      wr_nxt   = wr_wrap;
      full_nxt = (wr_wrap == (full_r ? rd_wrap : rd_r));
    end else if (dp_cmd.do_get) begin
      rd_nxt   = rd_wrap;
      full_nxt = 1'b0;
    end
  end

  assign held_nxt = held_of(wr_nxt, rd_nxt, full_nxt, cap_use);

  assign ram_re    = dp_cmd.rd_head || dp_cmd.rd_next;
  assign ram_raddr = dp_cmd.rd_head ? rd_r : pk_wrap;

  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (dp_cmd.do_put),
    .waddr (wr_r),
    .wdata (in_din),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= brf_pkg::CAP_RESET;
      wr_r   <= '0;
      rd_r   <= '0;
      full_r <= 1'b0;
    end else if (cfg_we) begin
      cap_r  <= cfg_wdata;
      wr_r   <= '0;
      rd_r   <= '0;
      full_r <= 1'b0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      full_r <= full_nxt;
    end
    if (ram_re) begin
      pk_r <= ram_raddr;
    end
    if (dp_cmd.out_load) begin
      out_r.status     <= dp_cmd.out_status;
      out_r.data_valid <= dp_cmd.out_ram;
      out_r.data_out   <= dp_cmd.out_ram ? ram_rdata : 8'd0;
      out_r.last       <= dp_cmd.out_last;
      out_r.occupancy  <= brf_pkg::OCC_W'(held_nxt);
      out_r.is_full    <= full_nxt;
      out_r.is_empty   <= !full_nxt && (wr_nxt == rd_nxt);
    end
  end

  assign out_data = out_r;

endmodule
